// ===== rtl/qslerp_pkg.sv =====
// shared types, pipeline stage map and arctangent constants for quaternion_slerp
package qslerp_pkg;

	localparam int FRAC = 14;
	localparam int ONE = 1 << FRAC;
	localparam int WORK = 30;
	localparam int NC = 16;
	localparam int NSQ = WORK + 1;
	localparam int NDQ = FRAC + 1;

	localparam int K_P1 = 1;
	localparam int K_P2 = 2;
	localparam int K_P3 = 3;
	localparam int K_P4 = 4;
	localparam int K_SQ = 5;
	localparam int K_VC = K_SQ + NSQ;
	localparam int K_TH = K_VC + NC;
	localparam int K_SC = K_TH + 1;
	localparam int K_DV = K_SC + NC;
	localparam int K_DQ = K_DV + 1;
	localparam int K_FM = K_DQ + NDQ;
	localparam int K_FO = K_FM + 1;
	localparam int NS = K_FO;

	typedef enum logic [1:0] {
		MODE_PASS_A,
		MODE_PASS_B,
		MODE_LINEAR,
		MODE_SLERP
	} mode_t;

	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][16:0] b;
		logic [15:0]      t;
		mode_t            mode;
	} side_t;

	function automatic logic signed [32:0] atan_step(input int i);
		logic signed [32:0] v;
		begin
			unique case (i)
				0: v = 33'sd843314857;
				1: v = 33'sd497837830;
				2: v = 33'sd263043837;
				3: v = 33'sd133525159;
				4: v = 33'sd67021688;
				5: v = 33'sd33543516;
				6: v = 33'sd16775852;
				7: v = 33'sd8388438;
				8: v = 33'sd4194284;
				9: v = 33'sd2097150;
				10: v = 33'sd1048576;
				default: v = (i <= WORK) ? (33'sd1 <<< (WORK - i)) : 33'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== rtl/quaternion_slerp.sv =====
// quaternion slerp pipeline: dot, sqrt, arccos and sine cordics, weight divide, blend
// throughput: one word per cycle; the whole pipe advances together and holds on output stall
// pipe length is set by the 31-step square root, two 16-step cordics and the 15-step divide
// reset: arst_n clears all valid bits and loads linear_threshold with 16382
module quaternion_slerp (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// res_x, res_y, res_z, res_w
	output logic [63:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int NS = qslerp_pkg::NS;
	localparam int NC = qslerp_pkg::NC;
	localparam int NSQ = qslerp_pkg::NSQ;
	localparam int NDQ = qslerp_pkg::NDQ;
	localparam int FRAC = qslerp_pkg::FRAC;

	logic adv;
	logic [14:0] thr_q;
	logic [NS:1] vld_s;
	qslerp_pkg::side_t side_s [1:NS];
	qslerp_pkg::side_t side_d [1:NS];

	// config port
	assign pready = 1'b1;
	assign prdata = {17'd0, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd16382;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			thr_q <= pwdata[14:0];
		end
	end

	// flow control
	assign adv = !vld_s[NS] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-1:1], s_tvalid};
		end
	end

	// stage 1: products
	logic signed [15:0] in_a [4];
	logic signed [15:0] in_b [4];
	logic signed [15:0] in_t;
	logic signed [31:0] prod_s1 [4];

	assign in_t = s_tdata[143:128];

	for (genvar i = 0; i < 4; i++) begin : g_in
		assign in_a[i] = s_tdata[16*i +: 16];
		assign in_b[i] = s_tdata[64 + 16*i +: 16];
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s1[i] <= in_a[i] * in_b[i];
			end
		end
	end

	// stage 2: dot, sign, cosine
	logic signed [33:0] dot;
	logic [32:0] dabs;
	logic [32:0] dclamp;
	logic dneg;
	logic lin_hit;
	logic [30:0] c_s2;

	always_comb begin
		dot = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'(prod_s1[3]);
		dneg = dot[33];
		dabs = dneg ? 33'(-dot) : 33'(dot);
		lin_hit = dabs >= 33'({thr_q, 14'd0});
		dclamp = (dabs > 33'(1 << (2*FRAC))) ? 33'(1 << (2*FRAC)) : dabs;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2 <= 31'(dclamp << (qslerp_pkg::WORK - 2*FRAC));
		end
	end

	// stages 3 and 4: radicand 2^60 - c^2
	logic [61:0] csq_s3;
	logic [30:0] c_s3;
	logic [60:0] rad_s4;
	logic [30:0] c_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			csq_s3 <= 62'(c_s2) * 62'(c_s2);
			c_s3 <= c_s2;
			rad_s4 <= 61'((62'd1 << 60) - csq_s3);
			c_s4 <= c_s3;
		end
	end

	// square root, one root bit per stage
	logic [60:0] sq_rem_s [NSQ];
	logic [30:0] sq_root_s [NSQ];
	logic [30:0] sq_c_s [NSQ];

	for (genvar j = 0; j < NSQ; j++) begin : g_sq
		localparam int K = NSQ - 1 - j;
		logic [60:0] rem_p;
		logic [30:0] root_p;
		logic [30:0] c_p;
		logic [61:0] trial;
		if (j == 0) begin : g_first
			assign rem_p = rad_s4;
			assign root_p = '0;
			assign c_p = c_s4;
		end else begin : g_next
			assign rem_p = sq_rem_s[j-1];
			assign root_p = sq_root_s[j-1];
			assign c_p = sq_c_s[j-1];
		end
		assign trial = (62'(root_p) << (K + 1)) | (62'd1 << (2*K));
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_c_s[j] <= c_p;
				if (62'(rem_p) >= trial) begin
					sq_rem_s[j] <= 61'(62'(rem_p) - trial);
					sq_root_s[j] <= root_p | (31'd1 << K);
				end else begin
					sq_rem_s[j] <= rem_p;
					sq_root_s[j] <= root_p;
				end
			end
		end
	end

	// vectoring cordic: angle of (c, s)
	logic signed [33:0] vx_s [NC];
	logic signed [33:0] vy_s [NC];
	logic signed [32:0] vz_s [NC];

	for (genvar i = 0; i < NC; i++) begin : g_vc
		logic signed [33:0] x_p;
		logic signed [33:0] y_p;
		logic signed [32:0] z_p;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		if (i == 0) begin : g_first
			assign x_p = $signed(34'(sq_c_s[NSQ-1]));
			assign y_p = $signed(34'(sq_root_s[NSQ-1]));
			assign z_p = '0;
		end else begin : g_next
			assign x_p = vx_s[i-1];
			assign y_p = vy_s[i-1];
			assign z_p = vz_s[i-1];
		end
		assign dx = y_p >>> i;
		assign dy = x_p >>> i;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_p[33]) begin
					vx_s[i] <= x_p + dx;
					vy_s[i] <= y_p - dy;
					vz_s[i] <= z_p + qslerp_pkg::atan_step(i);
				end else begin
					vx_s[i] <= x_p - dx;
					vy_s[i] <= y_p + dy;
					vz_s[i] <= z_p - qslerp_pkg::atan_step(i);
				end
			end
		end
	end

	// angle and partial angles
	logic [30:0] th;
	logic [14:0] wt1;
	logic [14:0] wt2;
	logic [45:0] pa1;
	logic [45:0] pa2;
	logic [30:0] ang_s [3];

	always_comb begin
		th = vz_s[NC-1][32] ? 31'd0 : vz_s[NC-1][30:0];
		wt2 = side_s[qslerp_pkg::K_TH-1].t[14:0];
		wt1 = 15'(qslerp_pkg::ONE - int'(wt2));
		pa1 = 46'(wt1) * 46'(th);
		pa2 = 46'(wt2) * 46'(th);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s[0] <= th;
			ang_s[1] <= pa1[44:14];
			ang_s[2] <= pa2[44:14];
		end
	end

	// rotation cordics: sine of th and of both partial angles
	logic signed [33:0] sx_s [3][NC];
	logic signed [33:0] sy_s [3][NC];
	logic signed [32:0] sz_s [3][NC];

	for (genvar u = 0; u < 3; u++) begin : g_sc
		for (genvar i = 0; i < NC; i++) begin : g_st
			logic signed [33:0] x_p;
			logic signed [33:0] y_p;
			logic signed [32:0] z_p;
			logic signed [33:0] dx;
			logic signed [33:0] dy;
			if (i == 0) begin : g_first
				assign x_p = 34'sd1 <<< qslerp_pkg::WORK;
				assign y_p = '0;
				assign z_p = $signed(33'(ang_s[u]));
			end else begin : g_next
				assign x_p = sx_s[u][i-1];
				assign y_p = sy_s[u][i-1];
				assign z_p = sz_s[u][i-1];
			end
			assign dx = y_p >>> i;
			assign dy = x_p >>> i;
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!z_p[32]) begin
						sx_s[u][i] <= x_p - dx;
						sy_s[u][i] <= y_p + dy;
						sz_s[u][i] <= z_p - qslerp_pkg::atan_step(i);
					end else begin
						sx_s[u][i] <= x_p + dx;
						sy_s[u][i] <= y_p - dy;
						sz_s[u][i] <= z_p + qslerp_pkg::atan_step(i);
					end
				end
			end
		end
	end

	// divide setup: numerators, divisor and overflow check
	logic [31:0] ysn [3];
	logic [46:0] num [2];
	logic [46:0] dn_s [2];
	logic dovf_s [2];
	logic [31:0] dd_s;

	for (genvar u = 0; u < 3; u++) begin : g_ys
		assign ysn[u] = sy_s[u][NC-1][33] ? 32'd0 : sy_s[u][NC-1][31:0];
	end

	for (genvar u = 0; u < 2; u++) begin : g_dv
		assign num[u] = (47'(ysn[u+1]) << FRAC) + 47'(ysn[0] >> 1);
		always_ff @(posedge clk) begin
			if (adv) begin
				dn_s[u] <= num[u];
				dovf_s[u] <= num[u] >= (47'(ysn[0]) << (FRAC + 1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s <= ysn[0];
		end
	end

	// restoring divide, one quotient bit per stage
	logic [46:0] dq_rem_s [2][NDQ];
	logic [14:0] dq_q_s [2][NDQ];
	logic dq_ovf_s [2][NDQ];
	logic [31:0] dq_d_s [NDQ];

	for (genvar j = 0; j < NDQ; j++) begin : g_dq
		localparam int K = NDQ - 1 - j;
		logic [31:0] d_p;
		logic [46:0] dsh;
		if (j == 0) begin : g_first
			assign d_p = dd_s;
		end else begin : g_next
			assign d_p = dq_d_s[j-1];
		end
		assign dsh = 47'(d_p) << K;
		always_ff @(posedge clk) begin
			if (adv) begin
				dq_d_s[j] <= d_p;
			end
		end
		for (genvar u = 0; u < 2; u++) begin : g_u
			logic [46:0] rem_p;
			logic [14:0] q_p;
			logic ovf_p;
			if (j == 0) begin : g_first
				assign rem_p = dn_s[u];
				assign q_p = '0;
				assign ovf_p = dovf_s[u];
			end else begin : g_next
				assign rem_p = dq_rem_s[u][j-1];
				assign q_p = dq_q_s[u][j-1];
				assign ovf_p = dq_ovf_s[u][j-1];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					dq_ovf_s[u][j] <= ovf_p;
					if (rem_p >= dsh) begin
						dq_rem_s[u][j] <= rem_p - dsh;
						dq_q_s[u][j] <= q_p | (15'd1 << K);
					end else begin
						dq_rem_s[u][j] <= rem_p;
						dq_q_s[u][j] <= q_p;
					end
				end
			end
		end
	end

	// weight select and final products
	logic [14:0] wq [2];
	logic [14:0] f1;
	logic [14:0] f2;
	qslerp_pkg::side_t fs;
	logic signed [32:0] m1_s [4];
	logic signed [32:0] m2_s [4];

	for (genvar u = 0; u < 2; u++) begin : g_wq
		assign wq[u] = (dq_ovf_s[u][NDQ-1] || dq_q_s[u][NDQ-1] > 15'(qslerp_pkg::ONE))
			? 15'(qslerp_pkg::ONE) : dq_q_s[u][NDQ-1];
	end

	always_comb begin
		fs = side_s[qslerp_pkg::K_FM-1];
		unique case (fs.mode)
			qslerp_pkg::MODE_PASS_A: begin
				f1 = 15'(qslerp_pkg::ONE);
				f2 = '0;
			end
			qslerp_pkg::MODE_PASS_B: begin
				f1 = '0;
				f2 = 15'(qslerp_pkg::ONE);
			end
			qslerp_pkg::MODE_LINEAR: begin
				f2 = fs.t[14:0];
				f1 = 15'(qslerp_pkg::ONE - int'(fs.t[14:0]));
			end
			default: begin
				f1 = wq[0];
				f2 = wq[1];
			end
		endcase
	end

	logic signed [15:0] res_s [4];

	for (genvar i = 0; i < 4; i++) begin : g_out
		logic signed [33:0] rsum;
		logic signed [19:0] rsh;
		always_ff @(posedge clk) begin
			if (adv) begin
				m1_s[i] <= 33'($signed(fs.a[i]) * $signed({1'b0, f1}));
				m2_s[i] <= 33'($signed(fs.b[i]) * $signed({1'b0, f2}));
			end
		end
		always_comb begin
			rsum = 34'(m1_s[i]) + 34'(m2_s[i]) + 34'sd8192;
			rsh = 20'(rsum >>> FRAC);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rsh > 20'sd32767) begin
					res_s[i] <= 16'sh7fff;
				end else if (rsh < -20'sd32768) begin
					res_s[i] <= -16'sd32768;
				end else begin
					res_s[i] <= 16'(rsh);
				end
			end
		end
	end

	assign m_tdata = {res_s[3], res_s[2], res_s[1], res_s[0]};

	// sideband line
	always_comb begin
		for (int k = 2; k <= NS; k++) begin
			side_d[k] = side_s[k-1];
		end
		for (int i = 0; i < 4; i++) begin
			side_d[1].a[i] = in_a[i];
			side_d[1].b[i] = 17'(in_b[i]);
		end
		side_d[1].t = in_t;
		if (in_t <= 16'sd0) begin
			side_d[1].mode = qslerp_pkg::MODE_PASS_A;
		end else if (in_t >= 16'(qslerp_pkg::ONE)) begin
			side_d[1].mode = qslerp_pkg::MODE_PASS_B;
		end else begin
			side_d[1].mode = qslerp_pkg::MODE_SLERP;
		end
		if (side_s[qslerp_pkg::K_P2-1].mode != qslerp_pkg::MODE_PASS_B && dneg) begin
			for (int i = 0; i < 4; i++) begin
				side_d[qslerp_pkg::K_P2].b[i] = 17'(-$signed(side_s[qslerp_pkg::K_P2-1].b[i]));
			end
		end
		if (side_s[qslerp_pkg::K_P2-1].mode == qslerp_pkg::MODE_SLERP && lin_hit) begin
			side_d[qslerp_pkg::K_P2].mode = qslerp_pkg::MODE_LINEAR;
		end
		if (side_s[qslerp_pkg::K_DV-1].mode == qslerp_pkg::MODE_SLERP && ysn[0] == 32'd0) begin
			side_d[qslerp_pkg::K_DV].mode = qslerp_pkg::MODE_LINEAR;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= NS; k++) begin
				side_s[k] <= side_d[k];
			end
		end
	end

endmodule

// ===== rtl/qslerp_checker.sv =====
// port-level checks for quaternion_slerp, bound to the top level
module qslerp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic         psel,
	input logic         penable,
	input logic         pwrite,
	input logic [2:0]   paddr,
	input logic [31:0]  pwdata,
	input logic [31:0]  prdata
);

	// output word held while stalled
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed under stall");

	// pipe moves whenever the output slot frees
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// threshold readback
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2]
		|=> prdata == {17'd0, $past(pwdata[14:0])})
		else $error("threshold readback mismatch");

endmodule

bind quaternion_slerp qslerp_checker u_qslerp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for quaternion_slerp: scoreboard class, stream and apb drivers
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT = 200000;
	localparam int DRAIN = 200;
	localparam logic [2:0] ADDR_LINEAR_THRESHOLD = 3'd0;
	localparam logic [14:0] THRESHOLDS [5] = '{15'd0, 15'd16384, 15'd8192, 15'd16382, 15'd15000};

	class slerp_scoreboard;
		logic [63:0] expected_words[$];
		logic [14:0] threshold;
		int mismatches;
		longint arctan[32];

		function new();
			longint low[11] = '{843314857, 497837830, 263043837, 133525159, 67021688,
				33543516, 16775852, 8388438, 4194284, 2097150, 1048576};
			threshold = 15'd16382;
			mismatches = 0;
			for (int i = 0; i < 32; i++)
				arctan[i] = (i < 11) ? low[i] : (i <= 30 ? (longint'(1) << (30 - i)) : 0);
		endfunction

		function longint root(longint unsigned n);
			longint unsigned res, bit_v;
			res = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > n)
				bit_v >>= 2;
			while (bit_v != 0) begin
				if (n >= res + bit_v) begin
					n -= res + bit_v;
					res = (res >> 1) + bit_v;
				end else begin
					res >>= 1;
				end
				bit_v >>= 2;
			end
			return longint'(res);
		endfunction

		function longint arc_of(longint x, longint y);
			longint z, dx, dy;
			z = 0;
			for (int i = 0; i < qslerp_pkg::NC; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += arctan[i];
				end else begin
					x -= dx; y += dy; z -= arctan[i];
				end
			end
			return z;
		endfunction

		function longint sine_of(longint z);
			longint x, y, dx, dy;
			x = longint'(1) << 30;
			y = 0;
			for (int i = 0; i < qslerp_pkg::NC; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= arctan[i];
				end else begin
					x += dx; y -= dy; z += arctan[i];
				end
			end
			return (y < 0) ? 0 : y;
		endfunction

		function longint ratio(longint part, longint whole);
			longint f;
			f = ((part << qslerp_pkg::FRAC) + whole / 2) / whole;
			return (f > qslerp_pkg::ONE) ? qslerp_pkg::ONE : f;
		endfunction

		function logic [15:0] clip(longint v);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		function logic [63:0] interpolate(logic [143:0] d);
			longint a[4], b[4], t, dot, f1, f2, c, s, th, yth, r;
			logic [63:0] res;
			for (int i = 0; i < 4; i++) begin
				a[i] = longint'($signed(d[16*i +: 16]));
				b[i] = longint'($signed(d[64 + 16*i +: 16]));
			end
			t = longint'($signed(d[143:128]));
			if (t <= 0 || t >= qslerp_pkg::ONE) begin
				for (int i = 0; i < 4; i++)
					res[16*i +: 16] = (t <= 0) ? a[i][15:0] : b[i][15:0];
				return res;
			end
			dot = 0;
			for (int i = 0; i < 4; i++)
				dot += a[i] * b[i];
			if (dot < 0) begin
				dot = -dot;
				for (int i = 0; i < 4; i++)
					b[i] = -b[i];
			end
			f1 = qslerp_pkg::ONE - t;
			f2 = t;
			if (dot < (longint'(threshold) << qslerp_pkg::FRAC)) begin
				c = (dot > (longint'(1) << (2 * qslerp_pkg::FRAC))) ?
					(longint'(1) << (2 * qslerp_pkg::FRAC)) : dot;
				c = c << (qslerp_pkg::WORK - 2 * qslerp_pkg::FRAC);
				s = root((64'd1 << 60) - longint'(c) * longint'(c));
				th = arc_of(c, s);
				if (th < 0)
					th = 0;
				yth = sine_of(th);
				if (yth > 0) begin
					f1 = ratio(sine_of(((qslerp_pkg::ONE - t) * th) >>> qslerp_pkg::FRAC), yth);
					f2 = ratio(sine_of((t * th) >>> qslerp_pkg::FRAC), yth);
				end
			end
			for (int i = 0; i < 4; i++) begin
				r = a[i] * f1 + b[i] * f2 + (longint'(1) << (qslerp_pkg::FRAC - 1));
				res[16*i +: 16] = clip(r >>> qslerp_pkg::FRAC);
			end
			return res;
		endfunction

		function void note_word(logic [143:0] d);
			expected_words.push_back(interpolate(d));
		endfunction

		function void check_word(logic [63:0] got);
			logic [63:0] want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word %h", got);
				return;
			end
			want = expected_words.pop_front();
			for (int i = 0; i < 4; i++)
				if (want[16*i +: 16] !== got[16*i +: 16]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("component %0d: expected %0d actual %0d (word %h)", i,
							$signed(want[16*i +: 16]), $signed(got[16*i +: 16]), got);
				end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// res_x, res_y, res_z, res_w
	logic [63:0]  m_tdata;
	logic         psel, penable, pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;
	logic         pready;

	slerp_scoreboard sb;
	bit steady;
	int cycles = 0;

	quaternion_slerp dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("quaternion_slerp verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= 22);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_word(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	task automatic send_word(logic [143:0] d);
		while (!steady && $urandom_range(0, 99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [14:0] v);
		pause_until_drained();
		repeat (DRAIN) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_LINEAR_THRESHOLD;
		pwdata <= {17'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.threshold = v;
	endtask

	function automatic logic [63:0] unit_quat();
		real q[4], n;
		logic [63:0] r;
		n = 0.0;
		for (int i = 0; i < 4; i++) begin
			q[i] = real'(int'($urandom_range(0, 65535)) - 32768) + 0.5;
			n += q[i] * q[i];
		end
		n = $sqrt(n);
		for (int i = 0; i < 4; i++)
			r[16*i +: 16] = 16'($rtoi(q[i] * 16384.0 / n));
		return r;
	endfunction

	function automatic logic [143:0] pack(logic [63:0] qa, logic [63:0] qb, int t);
		return {16'(t), qb, qa};
	endfunction

	function automatic logic [143:0] random_word();
		logic [63:0] qa, qb;
		int kind, t;
		kind = $urandom_range(0, 99);
		t = $urandom_range(1, qslerp_pkg::ONE - 1);
		if (kind < 8)
			t = int'($urandom_range(0, 65535)) - 32768;
		qa = unit_quat();
		if (kind < 50) begin
			qb = unit_quat();
		end else if (kind < 75) begin
			for (int i = 0; i < 4; i++)
				qb[16*i +: 16] = qa[16*i +: 16] + 16'(int'($urandom_range(0, 400)) - 200);
			if ($urandom_range(0, 1))
				for (int i = 0; i < 4; i++)
					qb[16*i +: 16] = -qb[16*i +: 16];
		end else begin
			qa = {$urandom, $urandom};
			qb = {$urandom, $urandom};
		end
		return pack(qa, qb, t);
	endfunction

	task automatic directed_words();
		logic [63:0] qa, qb, mx, mn, id, ix;
		mx = {4{16'h7fff}};
		mn = {4{16'h8000}};
		id = {16'd16384, 16'd0, 16'd0, 16'd0};
		ix = {16'd0, 16'd0, 16'd0, 16'd16384};
		qa = unit_quat();
		qb = unit_quat();
		send_word(pack(mn, mx, 0));
		send_word(pack(mx, mn, -32768));
		send_word(pack(mx, mn, qslerp_pkg::ONE));
		send_word(pack(mn, mx, 32767));
		send_word(pack(qa, qb, -1));
		send_word(pack(qa, qb, 1));
		send_word(pack(qa, qb, qslerp_pkg::ONE - 1));
		send_word(pack(qa, qb, qslerp_pkg::ONE / 2));
		send_word(pack(id, id, qslerp_pkg::ONE / 2));
		send_word(pack(id, ix, qslerp_pkg::ONE / 3));
		send_word(pack(id, {16'hc000, 48'd0}, qslerp_pkg::ONE / 4));
		send_word(pack(id, {16'hc000, 16'd0, 16'd0, 16'd100}, qslerp_pkg::ONE / 2));
		send_word(pack(mx, mx, qslerp_pkg::ONE / 2));
		send_word(pack(mx, mn, qslerp_pkg::ONE / 2));
		send_word(pack(id, mn, qslerp_pkg::ONE / 2));
		send_word(pack({16'd1, 48'd0}, {16'd1, 48'd0}, qslerp_pkg::ONE / 2));
		send_word(pack(64'd0, 64'd0, qslerp_pkg::ONE / 2));
		send_word(pack(qa, qa, qslerp_pkg::ONE / 5));
		send_word(pack(qa, {16'h5555, 16'haaaa, 16'h5555, 16'haaaa}, qslerp_pkg::ONE / 2));
		send_word(pack({16'haaaa, 16'h5555, 16'haaaa, 16'h5555}, mx, 12345));
	endtask

	initial begin
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		for (int k = 0; k < 250; k++) begin
			if (k == 120)
				pause_until_drained();
			send_word(random_word());
		end
		for (int p = 0; p < 5; p++) begin
			write_threshold(THRESHOLDS[p]);
			steady = (p == 1);
			directed_words();
			for (int k = 0; k < 280; k++)
				send_word(random_word());
			steady = 1'b0;
		end
		pause_until_drained();
		repeat (DRAIN) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("quaternion_slerp verification clean");
		else
			$display("quaternion_slerp verification failed");
		$finish;
	end

endmodule

// ===== quaternion_slerp.f =====
rtl/qslerp_pkg.sv
rtl/quaternion_slerp.sv
rtl/qslerp_checker.sv
tb/tb_top.sv
